[rtl/core/bdq_pkg.sv]
// Shared definitions for the bounded deque with search.
// Holds the depth, index widths, request and status codes, and ring arithmetic.
// No dependencies.
`default_nettype none

package bdq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [2:0] {
        K_PUSH_FRONT = 3'd0,
        K_PUSH_BACK  = 3'd1,
        K_POP_FRONT  = 3'd2,
        K_POP_BACK   = 3'd3,
        K_CONTAINS   = 3'd4,
        K_CLEAR      = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Ring position base + offset, where base < DEPTH and offset <= DEPTH.
    function automatic t_idx ring_add(input t_idx base, input t_cnt offset);
        logic [CNT_W:0] sum;
        begin
            sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
            if (sum >= (CNT_W + 1)'(DEPTH)) begin
                sum = sum - (CNT_W + 1)'(DEPTH);
            end
            ring_add = sum[IDX_W-1:0];
        end
    endfunction

    function automatic t_idx ring_inc(input t_idx pos);
        begin
            if (pos == IDX_W'(DEPTH - 1)) begin
                ring_inc = '0;
            end else begin
                ring_inc = pos + IDX_W'(1);
            end
        end
    endfunction

    function automatic t_idx ring_dec(input t_idx pos);
        begin
            if (pos == '0) begin
                ring_dec = IDX_W'(DEPTH - 1);
            end else begin
                ring_dec = pos - IDX_W'(1);
            end
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/bounded_deque_with_search.sv]
// Top level of the bounded double-ended queue with membership search.
// Depends on bdq_pkg for the depth, the request and status codes and ring arithmetic.
//
// Channel   Direction  Handshake               Word
// request   in         start & !busy           i_kind, i_value
// result    out        o_done (one cycle)      o_popped_value, o_found, o_status
//
// Pushes, clear, unknown requests, pops from an empty queue and a search of an
// empty queue are answered directly: the result strobes in the cycle after acceptance
// and busy stays low, so a new word may be issued right away.
// A pop that removes an entry waits in the pop state for the registered read
// of the entry memory; busy is high for one cycle.
// A search reads one entry per cycle from the front and stops at the first
// match or after the last entry.
// Reset (synchronous, active low) empties the queue; memory contents are kept.
// The receiver cannot stall, so every result is shown for exactly one cycle.
`default_nettype none

module bounded_deque_with_search
    import bdq_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_kind,
    input  wire logic signed [31:0] i_value,
    output logic                    o_done,
    output logic signed [31:0]      o_popped_value,
    output logic                    o_found,
    output logic [1:0]              o_status
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    // Entry memory: one write port, one registered read port.
    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] r_rd_data;

    t_state             r_state, n_state;
    t_idx               r_front, n_front;
    t_cnt               r_count, n_count;
    t_idx               r_scan_pos, n_scan_pos;
    t_cnt               r_scan_left, n_scan_left;
    logic signed [31:0] r_value, n_value;
    logic               r_done, n_done;
    logic signed [31:0] r_popped, n_popped;
    logic               r_found, n_found;
    t_status            r_status, n_status;

    logic  accept;
    logic  wr_en;
    t_idx  wr_addr;
    t_idx  rd_addr;
    logic  is_full;
    logic  is_empty;
    t_cnt  count_m1;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && (r_state == S_IDLE);
    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);
    assign count_m1 = r_count - CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_scan_pos  = r_scan_pos;
        n_scan_left = r_scan_left;
        n_value     = r_value;
        n_done      = 1'b0;
        n_popped    = r_popped;
        n_found     = r_found;
        n_status    = r_status;
        wr_en       = 1'b0;
        wr_addr     = r_front;
        rd_addr     = r_front;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // Default result: zero payload, ok status.
                    n_popped = '0;
                    n_found  = 1'b0;
                    n_status = ST_OK;
                    n_done   = 1'b1;
                    n_value  = i_value;
                    case (t_kind'(i_kind))
                        K_PUSH_FRONT: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = ring_dec(r_front);
                                n_front = ring_dec(r_front);
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        K_PUSH_BACK: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = ring_add(r_front, r_count);
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        K_POP_FRONT: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // Pointers move now; the data arrives next cycle.
                                rd_addr = r_front;
                                n_front = ring_inc(r_front);
                                n_count = count_m1;
                                n_done  = 1'b0;
                                n_state = S_POP;
                            end
                        end
                        K_POP_BACK: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                rd_addr = ring_add(r_front, count_m1);
                                n_count = count_m1;
                                n_done  = 1'b0;
                                n_state = S_POP;
                            end
                        end
                        K_CONTAINS: begin
                            if (!is_empty) begin
                                // Start the scan at the front entry.
                                rd_addr     = r_front;
                                n_scan_pos  = ring_inc(r_front);
                                n_scan_left = count_m1;
                                n_done      = 1'b0;
                                n_state     = S_SCAN;
                            end
                        end
                        K_CLEAR: begin
                            n_front = '0;
                            n_count = '0;
                        end
                        default: begin
                            // Unknown kinds leave the queue as it is.
                        end
                    endcase
                end
            end
            S_POP: begin
                n_popped = r_rd_data;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            S_SCAN: begin
                // r_rd_data holds the entry read in the previous cycle.
                if (r_rd_data == r_value) begin
                    n_found = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_scan_left == '0) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_addr     = r_scan_pos;
                    n_scan_pos  = ring_inc(r_scan_pos);
                    n_scan_left = r_scan_left - CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_value;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_pos  <= n_scan_pos;
        r_scan_left <= n_scan_left;
        r_value     <= n_value;
        r_popped    <= n_popped;
        r_found     <= n_found;
        r_status    <= n_status;
    end

    assign o_done         = r_done;
    assign o_popped_value = r_popped;
    assign o_found        = r_found;
    assign o_status       = r_status;

    // An accepted word either yields its result next cycle or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_done || busy))
        else $error("accepted word neither answered nor in progress");

    // The entry count never exceeds the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // Leaving the pop or scan state always produces a result.
    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

    // A full or empty status never comes with a popped value or a match.
    a_status_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_FULL || o_status == ST_EMPTY))
            |-> (o_popped_value == '0 && !o_found))
        else $error("error status with nonzero payload");

endmodule

`default_nettype wire
